// File: hdl/lodp_pkg.sv
// Shared types, character constants and decode helpers for the load-file parser.
// Used by every module of the parser; depends on nothing.
`default_nettype none

package lodp_pkg;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_text;
	} item_t;

	typedef struct packed {
		logic [14:0] word_position;
		logic [23:0] word_value;
		logic        finished;
		logic [15:0] total_words;
		logic        overflowed;
	} res_t;

	localparam int unsigned MAX_RES = 3;

	typedef struct packed {
		logic [1:0]              cnt;
		res_t [MAX_RES-1:0]      ent;
	} bundle_t;

	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	localparam logic [7:0] CH_US    = 8'h5F;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_X     = 8'h58;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_N     = 8'h4E;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CASE_OFS = 8'd32;

	localparam logic [23:0] MEM_P     = 24'd0;
	localparam logic [23:0] MEM_X     = 24'd1;
	localparam logic [23:0] MEM_OTHER = 24'd2;

	localparam logic [2:0] KW_DATA_LEN = 3'd4;
	localparam logic [2:0] KW_END_LEN  = 3'd3;
	localparam logic [2:0] ADDR_DIGITS = 3'd4;
	localparam logic [2:0] WORD_DIGITS = 3'd6;

	function automatic logic is_eol(input logic [7:0] c);
		return (c == CH_CR) || (c == CH_LF);
	endfunction

	function automatic logic letter_is(input logic [7:0] c, input logic [7:0] up);
		return (c == up) || (c == (up + CASE_OFS));
	endfunction

	// digits give their value; anything else gives (c - 87) mod 16
	function automatic logic [3:0] nibble(input logic [7:0] c);
		if ((c >= CH_0) && (c <= CH_9))
			return c[3:0];
		return c[3:0] + 4'd9;
	endfunction

	function automatic logic [7:0] kw_data_ch(input logic [1:0] idx);
		logic [7:0] r;
		unique case (idx)
			2'd0: r = CH_D;
			2'd1: r = CH_A;
			2'd2: r = CH_T;
			default: r = CH_A;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] kw_end_ch(input logic [1:0] idx);
		logic [7:0] r;
		unique case (idx)
			2'd0: r = CH_E;
			2'd1: r = CH_N;
			default: r = CH_D;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// File: hdl/lodp_front.sv
// Front end: keyword and section parser, one text byte per transfer.
// Produces a bundle of up to three result words per byte; uses lodp_pkg.
`default_nettype none

module lodp_front #(
	parameter int unsigned OUT_WORDS = 32768
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire lodp_pkg::item_t item,
	input  wire logic            take,
	output lodp_pkg::bundle_t    bundle
);
	import lodp_pkg::*;

	localparam int unsigned PW = $clog2(OUT_WORDS + 1);
	localparam logic [PW-1:0] OUT_LIM = PW'(OUT_WORDS);

	typedef enum logic [9:0] {
		PH_SEEK     = 10'b0000000001,
		PH_KW_FIRST = 10'b0000000010,
		PH_KW_DATA  = 10'b0000000100,
		PH_KW_END   = 10'b0000001000,
		PH_SPACES   = 10'b0000010000,
		PH_SKIP_ONE = 10'b0000100000,
		PH_ADDR     = 10'b0001000000,
		PH_HDR_TAIL = 10'b0010000000,
		PH_BODY     = 10'b0100000000,
		PH_DONE     = 10'b1000000000
	} phase_t;

	phase_t      phase_q, phase_d, phase_dec;
	logic [2:0]  kw_q, kw_d;
	logic        als_q, als_d;
	logic [2:0]  dig_q, dig_d;
	logic [23:0] part_q, part_d;
	logic [PW-1:0] npos_q, npos_d;
	logic [14:0] slot_q, slot_d;
	logic [15:0] scnt_q, scnt_d;
	logic        open_q, open_d;
	logic        ovf_q, ovf_d;

	logic        wr_a, cnt_word, rsv, close_b, fin_kw, fin;
	logic [23:0] va;
	logic [7:0]  c;
	logic [3:0]  nib;
	logic [23:0] shifted;
	logic [2:0]  dig_inc;

	assign c       = item.char_code;
	assign nib     = nibble(c);
	assign shifted = {part_q[19:0], nib};
	assign dig_inc = dig_q + 3'd1;

	always_comb begin
		phase_dec = phase_q;
		kw_d      = kw_q;
		als_d     = als_q;
		dig_d     = dig_q;
		part_d    = part_q;
		wr_a      = 1'b0;
		cnt_word  = 1'b0;
		va        = '0;
		rsv       = 1'b0;
		close_b   = 1'b0;
		fin_kw    = 1'b0;
		unique case (phase_q)
			PH_DONE: begin
			end
			PH_KW_FIRST: begin
				kw_d = 3'd1;
				if (letter_is(c, CH_D)) begin
					phase_dec = PH_KW_DATA;
				end else if (letter_is(c, CH_E)) begin
					phase_dec = PH_KW_END;
				end else begin
					phase_dec = PH_SEEK;
					als_d     = is_eol(c);
				end
			end
			PH_KW_DATA: begin
				if ((kw_q < KW_DATA_LEN) && letter_is(c, kw_data_ch(kw_q[1:0]))) begin
					kw_d = kw_q + 3'd1;
					if ((kw_q + 3'd1) == KW_DATA_LEN)
						phase_dec = PH_SPACES;
				end else begin
					phase_dec = PH_SEEK;
					als_d     = is_eol(c);
				end
			end
			PH_KW_END: begin
				if ((kw_q < KW_END_LEN) && letter_is(c, kw_end_ch(kw_q[1:0]))) begin
					kw_d = kw_q + 3'd1;
					if ((kw_q + 3'd1) == KW_END_LEN)
						fin_kw = 1'b1;
				end else begin
					phase_dec = PH_SEEK;
					als_d     = is_eol(c);
				end
			end
			PH_SPACES: begin
				if (c != CH_SP) begin
					wr_a      = 1'b1;
					va        = (c == CH_P) ? MEM_P : ((c == CH_X) ? MEM_X : MEM_OTHER);
					phase_dec = PH_SKIP_ONE;
				end
			end
			PH_SKIP_ONE: begin
				dig_d     = '0;
				part_d    = '0;
				phase_dec = PH_ADDR;
			end
			PH_ADDR: begin
				part_d = {8'd0, shifted[15:0]};
				dig_d  = dig_inc;
				if (dig_inc >= ADDR_DIGITS) begin
					wr_a      = 1'b1;
					va        = {8'd0, shifted[15:0]};
					dig_d     = '0;
					part_d    = '0;
					rsv       = 1'b1;
					als_d     = 1'b0;
					phase_dec = PH_HDR_TAIL;
				end
			end
			PH_HDR_TAIL: begin
				if (is_eol(c)) begin
					als_d     = 1'b1;
					phase_dec = PH_BODY;
				end
			end
			PH_BODY: begin
				if (dig_q != 3'd0) begin
					part_d = shifted;
					dig_d  = dig_inc;
					if (dig_inc >= WORD_DIGITS) begin
						wr_a     = 1'b1;
						cnt_word = 1'b1;
						va       = shifted;
						dig_d    = '0;
						part_d   = '0;
					end
				end else if (is_eol(c)) begin
					als_d = 1'b1;
				end else if (als_q && (c == CH_US)) begin
					close_b   = 1'b1;
					als_d     = 1'b0;
					phase_dec = PH_KW_FIRST;
				end else if (c == CH_SP) begin
					als_d = 1'b0;
				end else begin
					als_d  = 1'b0;
					part_d = {20'd0, nib};
					dig_d  = 3'd1;
				end
			end
			default: begin
				if (als_q && (c == CH_US)) begin
					als_d     = 1'b0;
					phase_dec = PH_KW_FIRST;
				end else begin
					phase_dec = PH_SEEK;
					als_d     = is_eol(c);
				end
			end
		endcase
	end

	assign fin     = fin_kw || (item.end_of_text && (phase_q != PH_DONE));
	assign phase_d = fin ? PH_DONE : phase_dec;

	logic [PW-1:0] pos1, pos2;
	logic          ovf1, ovf2, open1;
	logic [15:0]   scnt1, scnt2;
	logic [14:0]   slot1;
	logic [1:0]    n;

	// word write, slot reservation, section close, status: in that order
	always_comb begin
		bundle = '0;
		n      = 2'd0;
		pos1   = npos_q;
		ovf1   = ovf_q;
		scnt1  = scnt_q;
		if (wr_a) begin
			if (npos_q < OUT_LIM) begin
				bundle.ent[n] = '{word_position: 15'(npos_q), word_value: va,
					finished: 1'b0, total_words: 16'd0, overflowed: ovf_q};
				n    = n + 2'd1;
				pos1 = npos_q + 1'b1;
				if (cnt_word)
					scnt1 = scnt_q + 16'd1;
			end else begin
				ovf1 = 1'b1;
			end
		end
		pos2  = pos1;
		ovf2  = ovf1;
		scnt2 = scnt1;
		slot1 = slot_q;
		open1 = open_q;
		if (rsv) begin
			scnt2 = '0;
			if (pos1 < OUT_LIM) begin
				slot1 = 15'(pos1);
				pos2  = pos1 + 1'b1;
				open1 = 1'b1;
			end else begin
				ovf2  = 1'b1;
				open1 = 1'b0;
			end
		end
		open_d = open1;
		if ((close_b || fin) && open1) begin
			bundle.ent[n] = '{word_position: slot1, word_value: {8'd0, scnt2},
				finished: 1'b0, total_words: 16'd0, overflowed: ovf2};
			n      = n + 2'd1;
			open_d = 1'b0;
		end
		if (fin) begin
			bundle.ent[n] = '{word_position: 15'd0, word_value: 24'd0,
				finished: 1'b1, total_words: 16'(pos2), overflowed: ovf2};
			n = n + 2'd1;
		end
		bundle.cnt = n;
		npos_d     = pos2;
		ovf_d      = ovf2;
		scnt_d     = scnt2;
		slot_d     = slot1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEEK;
			kw_q    <= '0;
			als_q   <= 1'b1;
			dig_q   <= '0;
			part_q  <= '0;
			npos_q  <= '0;
			slot_q  <= '0;
			scnt_q  <= '0;
			open_q  <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (take) begin
			phase_q <= phase_d;
			kw_q    <= kw_d;
			als_q   <= als_d;
			dig_q   <= dig_d;
			part_q  <= part_d;
			npos_q  <= npos_d;
			slot_q  <= slot_d;
			scnt_q  <= scnt_d;
			open_q  <= open_d;
			ovf_q   <= ovf_d;
		end
	end

endmodule

`default_nettype wire

// File: hdl/lodp_queue.sv
// Short bundle queue between the parser front end and the result back end.
// Uses lodp_pkg for the bundle and status types.
`default_nettype none

module lodp_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr,
	input  wire lodp_pkg::bundle_t wdata,
	input  wire logic              rd,
	output lodp_pkg::bundle_t      head,
	output lodp_pkg::q_stat_t      qs
);
	import lodp_pkg::*;

	bundle_t         mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wp_q, rp_q;
	logic [Q_AW:0]   cnt_q;

	assign head     = mem_q[rp_q];
	assign qs.full  = (cnt_q == (Q_AW + 1)'(Q_DEPTH));
	assign qs.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= wp_q + 1'b1;
			if (rd)
				rp_q <= rp_q + 1'b1;
			if (wr && !rd)
				cnt_q <= cnt_q + 1'b1;
			else if (rd && !wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// File: hdl/lodp_back.sv
// Back end: unpacks bundles into single results and holds the output register.
// Uses lodp_pkg for the result and bundle types.
`default_nettype none

module lodp_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lodp_pkg::bundle_t head,
	input  wire lodp_pkg::q_stat_t qs,
	input  wire logic              pop,
	output logic                   q_pop,
	output logic                   empty,
	output lodp_pkg::res_t         result
);
	import lodp_pkg::*;

	res_t       out_q;
	logic       out_vld_q;
	bundle_t    bun_q;
	logic [1:0] idx_q, cnt_q;
	logic       have_rem, load;
	res_t       rem_sel;

	assign have_rem = (idx_q < cnt_q);
	assign load     = !out_vld_q || pop;
	assign q_pop    = load && !have_rem && !qs.empty;
	assign empty    = !out_vld_q;
	assign result   = out_q;

	always_comb begin
		case (idx_q)
			2'd1:    rem_sel = bun_q.ent[1];
			2'd2:    rem_sel = bun_q.ent[2];
			default: rem_sel = bun_q.ent[0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (have_rem) begin
				out_q <= rem_sel;
			end else if (!qs.empty) begin
				out_q <= head.ent[0];
				bun_q <= head;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			idx_q     <= '0;
			cnt_q     <= '0;
		end else if (load) begin
			if (have_rem) begin
				idx_q     <= idx_q + 2'd1;
				out_vld_q <= 1'b1;
			end else if (!qs.empty) begin
				idx_q     <= 2'd1;
				cnt_q     <= head.cnt;
				out_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/lod_text_to_dsp_word_parser_core.sv
// Top level of the load-file text parser: front end, bundle queue, back end.
// Depends on lodp_pkg, lodp_front, lodp_queue and lodp_back.
//
// Input channel: one text byte per transfer (push/full), with end_of_text on
// the last byte. Result channel: one image word per transfer (empty/pop); the
// oldest result sits on the result port while empty is low.
// The front end takes one byte per cycle while full is low and turns it into
// zero to three results in the same cycle; these wait as one entry in a
// four-entry queue. The back end moves one result per cycle into its output
// register while the receiver keeps up; a result passes through the queue and
// then the output register. Sustained rate: one byte per cycle while results
// are drained as fast as they are made; bytes that make several results hand
// them out one per cycle, and full rises once the queue holds four pending entries.
// When the receiver stalls, the output register holds its result, the queue
// fills and full then holds off new bytes; nothing is dropped.
// After END or the last byte, a status result with finished set closes the
// stream; later bytes are taken and ignored until reset.
// Reset clears the parser to seek the first keyword line, empties the queue
// and the output register.
`default_nettype none

module lod_text_to_dsp_word_parser_core #(
	parameter int unsigned OUT_WORDS = 32768
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	output logic                 full,
	input  wire lodp_pkg::item_t item,
	output logic                 empty,
	input  wire logic            pop,
	output lodp_pkg::res_t       result
);
	import lodp_pkg::*;

	bundle_t bundle, head;
	q_stat_t qs;
	logic    take, q_wr, q_pop;

	assign full = qs.full;
	assign take = push && !qs.full;
	assign q_wr = take && (bundle.cnt != 2'd0);

	lodp_front #(
		.OUT_WORDS(OUT_WORDS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.take   (take),
		.bundle (bundle)
	);

	lodp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  (bundle),
		.rd     (q_pop),
		.head   (head),
		.qs     (qs)
	);

	lodp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qs     (qs),
		.pop    (pop),
		.q_pop  (q_pop),
		.empty  (empty),
		.result (result)
	);

	a_no_wr_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr |-> !qs.full)
		else $error("bundle written into full queue");

	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		qs.full |-> !qs.empty)
		else $error("queue status inconsistent");

	a_status_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.finished) |->
			(result.word_position == 15'd0 && result.word_value == 24'd0))
		else $error("status result carries a word");

	a_total_on_status: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.finished) |-> (result.total_words == 16'd0))
		else $error("word count shown before finish");

endmodule

`default_nettype wire

// File: verif/tb_lod_text_to_dsp_word_parser_core.sv
`timescale 1ns / 1ps
// Self-checking bench for lod_text_to_dsp_word_parser_core: load-file text goes in one byte
// per transfer, and every image word that comes out is checked against an in-bench parser.
// Depends on lodp_pkg and the core RTL.

module tb_lod_text_to_dsp_word_parser_core;
	import lodp_pkg::*;

	localparam int unsigned IMG_WORDS   = 256;
	localparam int unsigned STALL_LIMIT = 1000;

	typedef enum logic [3:0] {
		PH_SEEK, PH_KW_FIRST, PH_KW_DATA, PH_KW_END, PH_TYPE,
		PH_SKIP, PH_ADDR, PH_HDR_TAIL, PH_BODY, PH_DONE
	} parse_phase_e;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  push = 1'b0;
	logic  full;
	item_t text_byte = '0;
	logic  empty;
	logic  pop = 1'b0;
	res_t  word_out;

	lod_text_to_dsp_word_parser_core #(.OUT_WORDS(IMG_WORDS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (text_byte),
		.empty  (empty),
		.pop    (pop),
		.result (word_out)
	);

	always #5 clk = ~clk;

	item_t       text_bytes[$];
	res_t        pending_words[$];
	int          errors = 0;
	int unsigned idle_cycles = 0;
	bit          took_byte = 1'b0;
	bit          took_word = 1'b0;
	int unsigned push_gap = 0;
	int unsigned pop_gap = 0;
	bit          push_calm = 1'b0;
	bit          pop_calm = 1'b0;

	// parser state
	parse_phase_e phase = PH_SEEK;
	logic [3:0]   kw_cnt = '0;
	logic         line_start = 1'b1;
	logic [2:0]   digits = '0;
	logic [23:0]  acc = '0;
	logic [15:0]  next_pos = '0;
	logic [14:0]  slot_pos = '0;
	logic [15:0]  sec_count = '0;
	logic         sec_open = 1'b0;
	logic         overflow = 1'b0;
	int           outs_now = 0;
	logic [7:0]   data_kw [4] = '{CH_D, CH_A, CH_T, CH_A};
	logic [7:0]   end_kw [3] = '{CH_E, CH_N, CH_D};

	function automatic logic is_line_end(input logic [7:0] c);
		return (c == 8'h0D) || (c == 8'h0A);
	endfunction

	function automatic logic letter_match(input logic [7:0] c, input logic [7:0] up);
		return (c == up) || (c == up + 8'd32);
	endfunction

	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [7:0] t;
		if (c >= "0" && c <= "9") begin
			t = c - "0";
		end else if (c >= "A" && c <= "F") begin
			t = c - "A" + 8'd10;
		end else begin
			t = c - 8'd87;
		end
		return t[3:0];
	endfunction

	function automatic void add_expect(input logic [14:0] pos, input logic [23:0] val,
			input logic fin);
		res_t r;
		if (outs_now < MAX_RES) begin
			r.word_position = pos;
			r.word_value    = val;
			r.finished      = fin;
			r.total_words   = fin ? next_pos : 16'd0;
			r.overflowed    = overflow;
			pending_words.push_back(r);
			outs_now++;
		end
	endfunction

	function automatic bit store_word(input logic [23:0] val);
		if (next_pos < IMG_WORDS) begin
			add_expect(next_pos[14:0], val, 1'b0);
			next_pos++;
			return 1'b1;
		end
		overflow = 1'b1;
		return 1'b0;
	endfunction

	function automatic void skip_rest(input logic [7:0] c);
		phase      = PH_SEEK;
		line_start = is_line_end(c);
	endfunction

	function automatic void close_section();
		if (sec_open) begin
			add_expect(slot_pos, {8'h00, sec_count}, 1'b0);
			sec_open = 1'b0;
		end
	endfunction

	function automatic void finish_parse();
		close_section();
		add_expect('0, '0, 1'b1);
		phase = PH_DONE;
	endfunction

	function automatic void parse_byte(input item_t it);
		logic [7:0] c;
		c = it.char_code;
		outs_now = 0;
		if (phase != PH_DONE) begin
			case (phase)
				PH_KW_FIRST: begin
					kw_cnt = 4'd1;
					if (letter_match(c, CH_D))
						phase = PH_KW_DATA;
					else if (letter_match(c, CH_E))
						phase = PH_KW_END;
					else
						skip_rest(c);
				end
				PH_KW_DATA: begin
					if (kw_cnt < KW_DATA_LEN && letter_match(c, data_kw[kw_cnt[1:0]])) begin
						kw_cnt++;
						if (kw_cnt == KW_DATA_LEN)
							phase = PH_TYPE;
					end else begin
						skip_rest(c);
					end
				end
				PH_KW_END: begin
					if (kw_cnt < KW_END_LEN && letter_match(c, end_kw[kw_cnt[1:0]])) begin
						kw_cnt++;
						if (kw_cnt == KW_END_LEN)
							finish_parse();
					end else begin
						skip_rest(c);
					end
				end
				PH_TYPE: begin
					if (c != CH_SP) begin
						void'(store_word(c == CH_P ? MEM_P : (c == CH_X ? MEM_X : MEM_OTHER)));
						phase = PH_SKIP;
					end
				end
				PH_SKIP: begin
					digits = '0;
					acc    = '0;
					phase  = PH_ADDR;
				end
				PH_ADDR: begin
					acc = {8'h00, acc[11:0], hex_value(c)};
					digits++;
					if (digits >= ADDR_DIGITS) begin
						void'(store_word(acc));
						digits    = '0;
						acc       = '0;
						sec_count = '0;
						if (next_pos < IMG_WORDS) begin
							slot_pos = next_pos[14:0];
							next_pos++;
							sec_open = 1'b1;
						end else begin
							overflow = 1'b1;
							sec_open = 1'b0;
						end
						line_start = 1'b0;
						phase      = PH_HDR_TAIL;
					end
				end
				PH_HDR_TAIL: begin
					if (is_line_end(c)) begin
						line_start = 1'b1;
						phase      = PH_BODY;
					end
				end
				PH_BODY: begin
					if (digits != 0) begin
						acc = {acc[19:0], hex_value(c)};
						digits++;
						if (digits >= WORD_DIGITS) begin
							if (store_word(acc))
								sec_count++;
							digits = '0;
							acc    = '0;
						end
					end else if (is_line_end(c)) begin
						line_start = 1'b1;
					end else if (line_start && c == CH_US) begin
						close_section();
						line_start = 1'b0;
						phase      = PH_KW_FIRST;
					end else if (c == CH_SP) begin
						line_start = 1'b0;
					end else begin
						line_start = 1'b0;
						acc        = {20'h0, hex_value(c)};
						digits     = 3'd1;
					end
				end
				default: begin
					if (line_start && c == CH_US) begin
						line_start = 1'b0;
						phase      = PH_KW_FIRST;
					end else begin
						skip_rest(c);
					end
				end
			endcase
			if (it.end_of_text && phase != PH_DONE)
				finish_parse();
		end
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= 100)
			$display("%0t: %s", $time, msg);
	endtask

	task automatic compare_field(input string name, input logic [23:0] got,
			input logic [23:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	task automatic check_word(input res_t got);
		res_t want;
		if (pending_words.size() == 0) begin
			report_mismatch($sformatf("unexpected word at %0d value %06h",
				got.word_position, got.word_value));
		end else begin
			want = pending_words.pop_front();
			compare_field("word_position", got.word_position, want.word_position);
			compare_field("word_value", got.word_value, want.word_value);
			compare_field("finished", got.finished, want.finished);
			compare_field("total_words", got.total_words, want.total_words);
			compare_field("overflowed", got.overflowed, want.overflowed);
		end
	endtask

	function automatic int unsigned pick_gap(input bit calm);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	always @(posedge clk) begin
		took_byte = arst_n && push && !full;
		took_word = arst_n && pop && !empty;
		if (took_byte)
			parse_byte(text_byte);
		if (took_word)
			check_word(word_out);
		if (took_byte || took_word || !arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("[lod_text_to_dsp_word_parser_core] ERROR");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (took_byte) begin
				void'(text_bytes.pop_front());
				push_gap = pick_gap(push_calm);
				if ($urandom_range(0, 39) == 0)
					push_calm = !push_calm;
			end
			if (!push || took_byte) begin
				if (push_gap > 0) begin
					push <= 1'b0;
					push_gap--;
				end else if (text_bytes.size() != 0) begin
					push      <= 1'b1;
					text_byte <= text_bytes[0];
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (took_word) begin
				pop_gap = pick_gap(pop_calm);
				if ($urandom_range(0, 39) == 0)
					pop_calm = !pop_calm;
			end else if (pop_gap == 0 && !pop_calm && $urandom_range(0, 19) == 0) begin
				pop_gap = $urandom_range(1, 4);
			end
			if (pop_gap > 0) begin
				pop <= 1'b0;
				pop_gap--;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	task automatic put(input logic [7:0] c, input bit eot = 1'b0);
		item_t it;
		it.char_code   = c;
		it.end_of_text = eot;
		text_bytes.push_back(it);
	endtask

	task automatic put_str(input string s);
		for (int i = 0; i < s.len(); i++)
			put(s[i]);
	endtask

	task automatic put_eol();
		case ($urandom_range(0, 3))
			0: put(8'h0D);
			1: put(8'h0A);
			2: put_str("\015\n");
			default: put_str("\n\n");
		endcase
	endtask

	function automatic logic [7:0] rand_digit();
		string hx;
		hx = "0123456789ABCDEFabcdef";
		if ($urandom_range(0, 99) < 88)
			return hx[$urandom_range(0, 21)];
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic put_body(input int words);
		int k;
		for (int w = 0; w < words; w++) begin
			case ($urandom_range(0, 9))
				0, 1: ;
				2: put_eol();
				3: put_str("  ");
				default: put(CH_SP);
			endcase
			k = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 5) : 6;
			for (int d = 0; d < 6; d++) begin
				if (d == k)
					put(8'h0A);
				else
					put(rand_digit());
			end
		end
		put_eol();
	endtask

	task automatic put_data_header();
		string kw;
		kw = "DATA";
		put(CH_US);
		for (int i = 0; i < 4; i++)
			put($urandom_range(0, 1) ? kw[i] : kw[i] + CASE_OFS);
		repeat ($urandom_range(0, 3)) put(CH_SP);
		case ($urandom_range(0, 5))
			0, 1: put(CH_P);
			2, 3: put(CH_X);
			4: put(CH_X + CASE_OFS);
			default: put(8'($urandom_range(0, 255)));
		endcase
		put(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : CH_SP);
		repeat (4) put(rand_digit());
		repeat ($urandom_range(0, 4)) put(8'($urandom_range(8'h21, 8'h7E)));
		put_eol();
	endtask

	task automatic put_other_section();
		string names [10];
		names = '{"IN", "SYMBOL", "D", "DAT", "DAX", "e", "En", "EX", "P", "dAt"};
		put(CH_US);
		put_str(names[$urandom_range(0, 9)]);
		if ($urandom_range(0, 1))
			put_str(" P 0100");
		put_eol();
		put_body($urandom_range(0, 3));
	endtask

	task automatic put_noise_line();
		logic [7:0] c;
		int n;
		n = $urandom_range(1, 12);
		for (int i = 0; i < n; i++) begin
			c = 8'($urandom_range(0, 255));
			if (is_line_end(c) || (i == 0 && c == CH_US))
				c = c ^ 8'h80;
			put(c);
		end
		put_eol();
	endtask

	initial begin
		int n_directed;
		int n;
		int r;

		// mixed-case keyword, padded type, lowest address, extreme words
		put_str("_dAtA  P:0000\015\nFFFFFF000000\n");
		// lower-case hex address, word across a line end, non-hex digits
		put_str("_data X ffff\n12\015\n3456 g#zZ.~\n");
		// skipped section, broken keyword, odd memory type
		put_str("_Sy 12\n_d\n_DATA\tq zg9Z\n");
		n_directed = text_bytes.size();

		while (text_bytes.size() < n_directed + 50) begin
			r = $urandom_range(0, 9);
			if (r < 6) begin
				put_data_header();
				n = $urandom_range(0, 6);
				put_body(n);
			end else if (r < 8) begin
				put_other_section();
			end else begin
				put_noise_line();
			end
		end

		case ($urandom_range(0, 2))
			0: put_str("_END\n");
			1: begin
				put_str("4A");
				put(rand_digit(), 1'b1);
			end
			default: begin
				put_data_header();
				put_body(3);
				put_str("_eNd");
			end
		endcase
		repeat ($urandom_range(1, 5)) put(8'($urandom_range(0, 255)));
		put(CH_E, 1'b1);
		put_str("_END\n");

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (text_bytes.size() != 0) @(negedge clk);
		while (pending_words.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);

		if (errors == 0)
			$display("[lod_text_to_dsp_word_parser_core] OK");
		else
			$display("[lod_text_to_dsp_word_parser_core] ERROR");
		$finish;
	end

endmodule
